FILE: rtl/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam int ACTION_W    = 2;
    localparam int IN_VALUE_W  = 32;
    localparam int STATUS_W    = 2;
    localparam int FRONT_W     = 32;
    localparam int OUT_CNT_W   = 5;

    localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]       t_count;

    typedef struct packed {
        logic   enq;
        logic   deq;
        t_value value;
    } t_cell_cmd;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occ,
    input  logic               i_left_ge,
    input  spq_pkg::t_value    i_left_val,
    input  spq_pkg::t_value    i_right_val,
    output spq_pkg::t_value    o_val,
    output logic               o_ge
);

    spq_pkg::t_value r_val;
    spq_pkg::t_value n_val;

    // stored entry is not smaller than the incoming value
    assign o_ge  = i_occ && (r_val >= i_cmd.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_cmd.enq) begin
            if (i_left_ge) begin
                n_val = i_left_val;
            end else if (o_ge || !i_occ) begin
                n_val = i_cmd.value;
            end
        end else if (i_cmd.deq) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: rtl/sorted_priority_queue.sv
// Sorted priority queue: a row of compare-and-shift cells keeps up to CAPACITY
// values in ascending order, smallest at the front. A request is taken on any
// cycle with i_start high (o_busy stays low), so one request per cycle is
// sustained. Its result appears on the next cycle for exactly one cycle,
// marked by o_done; all cells compare against the new value and shift in the
// same cycle. The receiver cannot stall: results must be captured on the cycle
// o_done is high.
module sorted_priority_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [spq_pkg::ACTION_W-1:0]     i_action,
    input  logic [spq_pkg::IN_VALUE_W-1:0]   i_item_value,
    output logic                             o_done,
    output logic [spq_pkg::STATUS_W-1:0]     o_status,
    output logic [spq_pkg::FRONT_W-1:0]      o_front_value,
    output logic [spq_pkg::OUT_CNT_W-1:0]    o_entry_count
);

    spq_pkg::t_count            r_count;
    spq_pkg::t_count            n_count;
    logic                       r_done;
    logic [spq_pkg::STATUS_W-1:0] r_status;
    logic [spq_pkg::STATUS_W-1:0] n_status;

    logic                       w_accept;
    logic                       w_full;
    logic                       w_empty;
    spq_pkg::t_cell_cmd         w_cmd;
    spq_pkg::t_value            w_val [spq_pkg::CAPACITY];
    logic                       w_ge  [spq_pkg::CAPACITY];
    logic [63:0]                w_front;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_full   = (r_count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
    assign w_empty  = (r_count == '0);

    assign w_cmd.enq   = w_accept && (i_action == spq_pkg::ACT_ENQUEUE) && !w_full;
    assign w_cmd.deq   = w_accept && (i_action == spq_pkg::ACT_DEQUEUE) && !w_empty;
    assign w_cmd.value = (spq_pkg::VALUE_WIDTH)'(i_item_value);

    genvar g;
    generate
        for (g = 0; g < spq_pkg::CAPACITY; g++) begin : g_cell
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_occ       (spq_pkg::CNT_W'(g) < r_count),
                .i_left_ge   ((g == 0) ? 1'b0 : w_ge[(g == 0) ? 0 : g - 1]),
                .i_left_val  (w_val[(g == 0) ? 0 : g - 1]),
                .i_right_val (w_val[(g == spq_pkg::CAPACITY - 1) ? g : g + 1]),
                .o_val       (w_val[g]),
                .o_ge        (w_ge[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        case (i_action)
            spq_pkg::ACT_ENQUEUE: begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            spq_pkg::ACT_DEQUEUE: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            spq_pkg::ACT_PEEK: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end
            end
            spq_pkg::ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
    end

    assign w_front       = w_empty ? 64'd0 : 64'(w_val[0]);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_front_value = w_front[spq_pkg::FRONT_W-1:0];
    assign o_entry_count = spq_pkg::OUT_CNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
        else $error("count exceeds capacity");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.enq |=> (r_count == $past(r_count) + 1'b1))
        else $error("enqueue did not grow count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == spq_pkg::ST_FULL)) |->
            (r_count == spq_pkg::CNT_W'(spq_pkg::CAPACITY)))
        else $error("full status with room left");

    a_front_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= spq_pkg::CNT_W'(2)) |-> (w_val[0] <= w_val[1]))
        else $error("front entries out of order");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == spq_pkg::ST_EMPTY)) |->
            ((o_front_value == '0) && (o_entry_count == '0)))
        else $error("empty status with data");

endmodule

FILE: tb/sv/spq_order_checker.sv
`timescale 1ns / 1ps

module spq_order_checker
    import spq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [IN_VALUE_W-1:0] i_item_value,
    input  logic                  i_done,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic [FRONT_W-1:0]    i_front_value,
    input  logic [OUT_CNT_W-1:0]  i_entry_count,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [FRONT_W-1:0]   front;
        logic [OUT_CNT_W-1:0] count;
    } t_spq_result;

    t_value      shadow_vals [CAPACITY];
    int          shadow_count;
    int          fail_total = 0;
    t_spq_result expected_results [$];

    // Applies one request to the shadow store and returns the response it should give.
    function automatic t_spq_result predict_outcome(input logic [ACTION_W-1:0] act,
                                                    input t_value val);
        t_spq_result res;
        int          pos;
        res.status = ST_OK;
        case (act)
            ACT_ENQUEUE: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < shadow_count && shadow_vals[pos] < val) pos++;
                    for (int i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[pos] = val;
                    shadow_count++;
                end
            end
            ACT_DEQUEUE: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (int i = 1; i < shadow_count; i++) shadow_vals[i-1] = shadow_vals[i];
                    shadow_count--;
                end
            end
            ACT_PEEK: begin
                if (shadow_count == 0) res.status = ST_EMPTY;
            end
            default: begin
                shadow_count = 0;
            end
        endcase
        res.front = (shadow_count > 0) ? FRONT_W'(shadow_vals[0]) : '0;
        res.count = OUT_CNT_W'(shadow_count);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_spq_result got;
        t_spq_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // response first: it belongs to a request taken on an earlier edge
            if (i_done) begin
                got = '{i_status, i_front_value, i_entry_count};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected response: expected none, %s %0d front %h count %0d",
                             $time, "actual status", got.status, got.front, got.count);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        fail_total++;
                    end
                    if (got.front !== want.front) begin
                        $display("%0t: front_value mismatch: expected %h, actual %h",
                                 $time, want.front, got.front);
                        fail_total++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                                 $time, want.count, got.count);
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(predict_outcome(i_action, t_value'(i_item_value)));
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

FILE: tb/sv/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic [ACTION_W-1:0]   i_action = ACT_PEEK;
    logic [IN_VALUE_W-1:0] i_item_value = '0;
    logic                  o_busy;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [FRONT_W-1:0]    o_front_value;
    logic [OUT_CNT_W-1:0]  o_entry_count;

    int fail_count;
    int pending;
    int idle_pct = 0;

    sorted_priority_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_action      (i_action),
        .i_item_value  (i_item_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_front_value (o_front_value),
        .o_entry_count (o_entry_count)
    );

    spq_order_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_action      (i_action),
        .i_item_value  (i_item_value),
        .i_done        (o_done),
        .i_status      (o_status),
        .i_front_value (o_front_value),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic issue_request(input logic [ACTION_W-1:0] act,
                                 input logic [IN_VALUE_W-1:0] val);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_action     <= act;
        i_item_value <= val;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // mix of extremes and a narrow range so equal values collide often
    function automatic logic [IN_VALUE_W-1:0] random_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return IN_VALUE_W'($urandom_range(15));
            4:       return {{(IN_VALUE_W-4){1'b1}}, 4'($urandom_range(15))};
            default: return IN_VALUE_W'($urandom());
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(input int enq_pct);
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return ACT_CLEAR;
        else if (r < 12)
            return ACT_PEEK;
        else if ($urandom_range(99) < enq_pct)
            return ACT_ENQUEUE;
        else
            return ACT_DEQUEUE;
    endfunction

    initial begin
        int enq_pct;
        int waited;
        enq_pct = 50;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 15;
        issue_request(ACT_PEEK, '1);
        issue_request(ACT_DEQUEUE, '1);
        issue_request(ACT_CLEAR, '0);
        issue_request(ACT_ENQUEUE, 32'h8000_0000);
        issue_request(ACT_ENQUEUE, '0);
        issue_request(ACT_ENQUEUE, '1);
        issue_request(ACT_ENQUEUE, 32'h8000_0000);
        issue_request(ACT_ENQUEUE, 32'h0000_0001);
        issue_request(ACT_PEEK, '0);
        issue_request(ACT_DEQUEUE, '0);
        for (int i = 0; i < 12; i++)
            issue_request(ACT_ENQUEUE, IN_VALUE_W'(i + 3) * 32'h1111_1111);
        issue_request(ACT_ENQUEUE, '0);
        issue_request(ACT_PEEK, '0);
        issue_request(ACT_CLEAR, '1);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 15 : (phase == 1) ? 82 : 0;
            for (int n = 0; n < 560; n++) begin
                if (n % 32 == 0) begin
                    case ($urandom_range(3))
                        0:       enq_pct = 15;
                        1:       enq_pct = 50;
                        2:       enq_pct = 75;
                        default: enq_pct = 95;
                    endcase
                end
                issue_request(pick_action(enq_pct), random_value());
            end
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);

        if (pending == 0 && fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
